@@ rtl/core/ecda_pkg.sv @@
// shared types and constants for the eye closure drowsiness alarm
`default_nettype none

package ecda_pkg;

  localparam int COORD_BITS    = 10;
  localparam int EAR_FRAC_BITS = 14;
  localparam int PAIR_W        = 40;
  localparam int TS_W          = 32;
  localparam int EAR_W         = 16;
  localparam int CFG_W         = 26;
  localparam int CFG_IDX_W     = 2;
  localparam int ACC_W         = 32;
  localparam int STATUS_W      = 3;
  localparam int NUM_LANES     = 6;

  localparam int D2_W     = 2 * COORD_BITS + 1;
  localparam int SQ_IN_W  = D2_W + 2 * EAR_FRAC_BITS;
  localparam int RT_W     = (SQ_IN_W + 1) / 2;
  localparam int SQ_W     = 2 * RT_W;
  localparam int RM_W     = RT_W + 2;
  localparam int SUM_W    = RT_W + 1;
  localparam int NUM_W    = SUM_W + EAR_FRAC_BITS;
  localparam int DEN_W    = RT_W + 1;
  localparam int DR_W     = DEN_W + 1;
  localparam int SAT_SH   = EAR_W + 1 - EAR_FRAC_BITS;
  localparam int CMP_W    = RT_W + SAT_SH;
  localparam int SQ_STEPS = RT_W;
  localparam int DV_STEPS = EAR_W;
  localparam int CNT_W    = $clog2(SQ_STEPS);

  localparam logic [EAR_W-1:0] THR_RST    = 16'd3277;
  localparam logic [CFG_W-1:0] ALARM_RST  = 26'd2000000;
  localparam logic [CFG_W-1:0] OCLEAR_RST = 26'd100000;
  localparam logic [CFG_W-1:0] SHORT_RST  = 26'd400000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OPEN         = 3'd0,
    ST_CLOSED       = 3'd1,
    ST_ALARM        = 3'd2,
    ST_NOFACE_WARN  = 3'd3,
    ST_NOFACE_IDLE  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EAR_THR    = 2'd0,
    CFG_ALARM_TIME = 2'd1,
    CFG_OPEN_CLEAR = 2'd2,
    CFG_SHORT_CLOSE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic acc;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/ecda_ctrl.sv @@
// sequencer for capture, square roots, divisions and state update
`default_nettype none

module ecda_ctrl import ecda_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_SQRT  = 7'b0000100,
    S_DINIT = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
          state_d = S_DINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DV_STEPS - 1)) begin
          state_d = S_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (!sts_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ecda_dp.sv @@
// datapath: distance roots, ratio dividers, timing accumulators, result register
`default_nettype none

module ecda_dp import ecda_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  wire                  cfg_valid_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  input  wire                  face_present_i,
  input  wire [TS_W-1:0]       timestamp_us_i,
  input  wire [PAIR_W-1:0]     pair0_i,
  input  wire [PAIR_W-1:0]     pair1_i,
  input  wire [PAIR_W-1:0]     pair2_i,
  input  wire [PAIR_W-1:0]     pair3_i,
  input  wire [PAIR_W-1:0]     pair4_i,
  input  wire [PAIR_W-1:0]     pair5_i,
  input  wire                  out_stall_i,
  output logic                 out_valid_o,
  output logic [STATUS_W-1:0]  eye_status_o,
  output logic [EAR_W-1:0]     average_ear_o,
  output logic [ACC_W-1:0]     closed_time_us_o
);

  localparam int C = COORD_BITS;

  // configuration
  logic [EAR_W-1:0] thr_q;
  logic [CFG_W-1:0] alarm_q, oclear_q, short_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      alarm_q  <= ALARM_RST;
      oclear_q <= OCLEAR_RST;
      short_q  <= SHORT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EAR_THR:     thr_q    <= cfg_data_i[EAR_W-1:0];
        CFG_ALARM_TIME:  alarm_q  <= cfg_data_i;
        CFG_OPEN_CLEAR:  oclear_q <= cfg_data_i;
        CFG_SHORT_CLOSE: short_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured frame
  logic              face_q;
  logic [TS_W-1:0]   ts_q;
  logic [PAIR_W-1:0] pr_q [NUM_LANES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      face_q   <= face_present_i;
      ts_q     <= timestamp_us_i;
      pr_q[0]  <= pair0_i;
      pr_q[1]  <= pair1_i;
      pr_q[2]  <= pair2_i;
      pr_q[3]  <= pair3_i;
      pr_q[4]  <= pair4_i;
      pr_q[5]  <= pair5_i;
    end
  end

  // six distance lanes, one root bit per step
  logic [RT_W-1:0] root_q [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam int K = l % 3;
    localparam int S = l / 3;
    localparam int P = (K == 0) ? 1 : ((K == 1) ? 2 : 0);
    localparam int Q = (K == 0) ? 5 : ((K == 1) ? 4 : 3);

    logic [C-1:0]      x1, y1, x2, y2, dx, dy;
    logic [2*C-1:0]    sx, sy;
    logic [D2_W-1:0]   d2;
    logic [SQ_W-1:0]   rad_q;
    logic [RM_W-1:0]   rem_q, cur, trial;
    logic              ge;

    assign x1 = pr_q[P][2*S*C +: C];
    assign y1 = pr_q[P][(2*S+1)*C +: C];
    assign x2 = pr_q[Q][2*S*C +: C];
    assign y2 = pr_q[Q][(2*S+1)*C +: C];
    assign dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    assign dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    assign sx = dx * dx;
    assign sy = dy * dy;
    assign d2 = {1'b0, sx} + {1'b0, sy};

    assign cur   = {rem_q[RM_W-3:0], rad_q[SQ_W-1 -: 2]};
    assign trial = {root_q[l], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        rad_q     <= SQ_W'({d2, {(2*EAR_FRAC_BITS){1'b0}}});
        rem_q     <= '0;
        root_q[l] <= '0;
      end else if (cmd_i.sqrt_step) begin
        rad_q     <= {rad_q[SQ_W-3:0], 2'b00};
        rem_q     <= ge ? cur - trial : cur;
        root_q[l] <= {root_q[l][RT_W-2:0], ge};
      end
    end
  end

  // two ratio dividers, one quotient bit per step
  logic [EAR_W-1:0] ratio [2];

  for (genvar e = 0; e < 2; e++) begin : g_eye
    logic [SUM_W-1:0] sum;
    logic [RT_W-1:0]  cw;
    logic [NUM_W-1:0] num;
    logic             sat_now, sat_q, dge;
    logic [DEN_W-1:0] den_q;
    logic [DR_W-1:0]  drem_q, t;
    logic [EAR_W-1:0] qs_q;

    assign cw      = root_q[3*e+2];
    assign sum     = {1'b0, root_q[3*e]} + {1'b0, root_q[3*e+1]};
    assign num     = {sum, {EAR_FRAC_BITS{1'b0}}};
    assign sat_now = (cw == '0) || (CMP_W'(sum) >= {cw, {SAT_SH{1'b0}}});
    assign t       = {drem_q[DR_W-2:0], qs_q[EAR_W-1]};
    assign dge     = t >= {1'b0, den_q};
    assign ratio[e] = sat_q ? {EAR_W{1'b1}} : qs_q;

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_init) begin
        sat_q  <= sat_now;
        den_q  <= {cw, 1'b0};
        drem_q <= DR_W'(num[NUM_W-1:EAR_W]);
        qs_q   <= num[EAR_W-1:0];
      end else if (cmd_i.div_step) begin
        drem_q <= dge ? t - {1'b0, den_q} : t;
        qs_q   <= {qs_q[EAR_W-2:0], dge};
      end
    end
  end

  logic [EAR_W:0] rsum;
  assign rsum = {1'b0, ratio[0]} + {1'b0, ratio[1]};

  // timing state
  logic [ACC_W-1:0] cacc_q, clast_q, oacc_q, olast_q;
  logic             cseen_q, oseen_q;
  logic [ACC_W-1:0] cel, oel, cnew_d, onew_d, cnew_q, onew_q;
  logic [ACC_W:0]   csum, osum;
  logic [EAR_W-1:0] avg_q;
  logic             closed_q;

  assign cel  = ts_q - clast_q;
  assign oel  = ts_q - olast_q;
  assign csum = {1'b0, cacc_q} + {1'b0, cel};
  assign osum = {1'b0, oacc_q} + {1'b0, oel};
  assign cnew_d = !cseen_q ? '0 : (csum[ACC_W] ? {ACC_W{1'b1}} : csum[ACC_W-1:0]);
  assign onew_d = !oseen_q ? '0 : (osum[ACC_W] ? {ACC_W{1'b1}} : osum[ACC_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      avg_q    <= rsum[EAR_W:1];
      closed_q <= rsum[EAR_W:1] < thr_q;
      cnew_q   <= cnew_d;
      onew_q   <= onew_d;
    end
  end

  logic             alarm, oclr;
  logic [ACC_W-1:0] cacc_d;
  status_e          status;

  assign alarm = cnew_q > ACC_W'(alarm_q);
  assign oclr  = (onew_q > ACC_W'(oclear_q)) || (cacc_q <= ACC_W'(short_q));

  always_comb begin
    cacc_d = cacc_q;
    status = ST_OPEN;
    if (!face_q) begin
      status = (cacc_q != '0) ? ST_NOFACE_WARN : ST_NOFACE_IDLE;
    end else if (closed_q) begin
      cacc_d = cnew_q;
      status = alarm ? ST_ALARM : ST_CLOSED;
    end else if (oclr) begin
      cacc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cacc_q  <= '0;
      clast_q <= '0;
      cseen_q <= 1'b0;
      oacc_q  <= '0;
      olast_q <= '0;
      oseen_q <= 1'b0;
    end else if (cmd_i.update && face_q) begin
      cacc_q <= cacc_d;
      if (closed_q) begin
        if (alarm) begin
          oacc_q <= '0;
        end
        clast_q <= ts_q;
        cseen_q <= 1'b1;
      end else begin
        oacc_q  <= onew_q;
        olast_q <= ts_q;
        oseen_q <= 1'b1;
        if (oclr) begin
          cseen_q <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      eye_status_o     <= status;
      average_ear_o    <= face_q ? avg_q : '0;
      closed_time_us_o <= cacc_d;
    end
  end

  assign sts_o.out_busy = out_valid_o && out_stall_i;

endmodule

`default_nettype wire

@@ rtl/core/eye_closure_drowsiness_alarm.sv @@
// top level of the eye closure drowsiness alarm
// a frame is captured, loaded, run through the six parallel 25-step square roots and then
//   the 16-step ratio division, accumulated and written to the output register; a new frame
//   is taken only after that update, which waits while a held result stalls
// the next frame is taken while a finished result still waits for its transfer
// reset: asynchronous, active low; clears the accumulated closed and open timing state and loads register defaults
`default_nettype none

module eye_closure_drowsiness_alarm import ecda_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  face_present_i,
  input  wire [TS_W-1:0]       timestamp_us_i,
  input  wire [PAIR_W-1:0]     pair0_i,
  input  wire [PAIR_W-1:0]     pair1_i,
  input  wire [PAIR_W-1:0]     pair2_i,
  input  wire [PAIR_W-1:0]     pair3_i,
  input  wire [PAIR_W-1:0]     pair4_i,
  input  wire [PAIR_W-1:0]     pair5_i,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [STATUS_W-1:0]  eye_status_o,
  output logic [EAR_W-1:0]     average_ear_o,
  output logic [ACC_W-1:0]     closed_time_us_o,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_W-1:0]      cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ecda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecda_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .face_present_i   (face_present_i),
    .timestamp_us_i   (timestamp_us_i),
    .pair0_i          (pair0_i),
    .pair1_i          (pair1_i),
    .pair2_i          (pair2_i),
    .pair3_i          (pair3_i),
    .pair4_i          (pair4_i),
    .pair5_i          (pair5_i),
    .out_stall_i      (out_stall),
    .out_valid_o      (out_valid),
    .eye_status_o     (eye_status_o),
    .average_ear_o    (average_ear_o),
    .closed_time_us_o (closed_time_us_o)
  );

endmodule

`default_nettype wire
